@@ src/hsrt_pkg.sv @@
// package: field types, constants and state-free helpers for the split ratio tuner
package hsrt_pkg;

  localparam int unsigned HistoryCapacity = 1024;
  localparam int unsigned MaxWindow       = 10;
  localparam int unsigned WinDepth        = 2 * MaxWindow;
  localparam int unsigned CountW          = $clog2(HistoryCapacity + 1);
  localparam int unsigned WinW            = $clog2(MaxWindow + 1);
  localparam int unsigned IdxW            = $clog2(WinDepth);
  localparam int unsigned SqW             = $clog2(MaxWindow * MaxWindow + 1);

  localparam logic [15:0] ShareReset = 16'd32768;
  localparam logic [15:0] ShareMin   = 16'd6554;
  localparam logic [15:0] ShareMax   = 16'd58982;
  localparam logic [47:0] EffSat     = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] Step001    = 48'd655;

  // reciprocals for exact floor division of a dividend below 2^36, quotient at bit 47
  localparam logic [63:0] RecipScale = 64'h0000_8000_0000_0000;
  localparam logic [42:0] Recip30    = 43'((RecipScale + 64'd29) / 64'd30);
  localparam logic [42:0] Recip100   = 43'((RecipScale + 64'd99) / 64'd100);
  localparam logic [42:0] Recip200   = 43'((RecipScale + 64'd199) / 64'd200);
  localparam logic [42:0] Recip2000  = 43'((RecipScale + 64'd1999) / 64'd2000);

  localparam logic [7:0] RegStrategy = 8'd0;
  localparam logic [7:0] RegEnable   = 8'd1;

  typedef enum logic [1:0] {
    MODE_GRADIENT = 2'd0,
    MODE_ENERGY   = 2'd1,
    MODE_BALANCE  = 2'd2,
    MODE_BLEND    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [31:0] quantum_time;
    logic [31:0] classical_time;
    logic [31:0] link_overhead;
    logic [16:0] fidelity_level;
    logic [16:0] quantum_usage;
    logic [16:0] cpu_usage;
    logic [16:0] gpu_usage;
    logic [31:0] q_energy;
    logic [31:0] c_energy;
  } metrics_t;

  typedef struct packed {
    logic [15:0] quantum_share;
    logic [15:0] classical_share;
    logic        divide_fault;
  } shares_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] data;
  } cfg_word_t;

endpackage

@@ src/hsrt_if.sv @@
// valid/ready channel interfaces for metrics, shares and configuration words
interface hsrt_in_if import hsrt_pkg::*; ();
  logic     valid;
  logic     ready;
  metrics_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hsrt_out_if import hsrt_pkg::*; ();
  logic    valid;
  logic    ready;
  shares_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hsrt_cfg_if import hsrt_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/hybrid_split_ratio_tuner_top.sv @@
// Split ratio tuner: takes metric words, walks a score history, emits updated shares.
//
// Channels: in_i takes one metric word (times, energies Q16.16, fractions Q1.16),
// out_o returns one share word per metric word (quantum share, classical share,
// divide fault flag), cfg_i writes strategy_mode (index 0) and tuning_enable
// (index 1); cfg_i is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce. Divisions by a variable go
// through one restoring divider, one quotient bit a cycle; divisions by 30, 100,
// 200 and 2000 are a reciprocal multiply done in two 18 x 43 bit halves. The
// window sum uses one adder, one entry a cycle. Steps from accept to out_o.valid:
// the time score and its scaling (no division on a zero time sum), the window
// walk, the gradient division when w is nonzero, the strategy step for the mode,
// then apply and register. With tuning disabled the word goes from idle straight
// to the output register.
// The block takes one word at a time; in_i is ready only in idle, so the next
// word is taken at the earliest in the cycle after the result is registered.
// The result sits in an output register; a stalled receiver holds it there,
// the next word is still taken and waits at the end of its work for the slot.
// Reset: share 0.5, empty history, strategy gradient, tuning enabled.
module hybrid_split_ratio_tuner_top import hsrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  hsrt_in_if.sink    in_i,
  hsrt_out_if.source out_o,
  hsrt_cfg_if.sink   cfg_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_TQ, S_SCORE, S_REC, S_WSET, S_ACC, S_GDIV, S_GQ,
    S_MODE, S_EQS, S_EQ, S_ECS, S_EC, S_EFS, S_EFQ, S_BLEND, S_STEPQ,
    S_APPLY, S_OUT, S_KLO, S_KHI
  } st_e;

  st_e st_q, ret_q;
  metrics_t m_q;
  logic [1:0]  mode_q;
  logic        en_q;
  logic [15:0] share_q;
  logic [CountW-1:0] count_q;
  logic [39:0] win_q [WinDepth];
  logic        fault_q;
  logic        neg_q;
  logic [32:0] t_q;
  logic [WinW-1:0] w_q;
  logic [IdxW:0]   j_q;
  logic signed [47:0] d_q;
  logic signed [47:0] g_q;
  logic [47:0] eq_q, ec_q;
  logic signed [17:0] ef_q;
  logic signed [47:0] step_q;
  logic        out_valid_q;
  shares_t     out_q;

  // shared divider
  logic [63:0] dn_q;
  logic [49:0] dd_q;
  logic [50:0] rem_q;
  logic [63:0] quo_q;
  logic [6:0]  cnt_q;

  // constant divider by reciprocal multiply
  logic [35:0] kx_q;
  logic [42:0] km_q;
  logic [78:0] kacc_q;
  logic [17:0] kmul_a;
  logic [60:0] kprod;
  logic [31:0] kq;

  logic [33:0] tsum;
  logic [18:0] usum;
  logic [39:0] s_num;
  logic [35:0] s_mag;
  logic signed [19:0] bf2;
  logic [19:0] bf2_mag;
  logic [50:0] div_r;
  logic        div_ge;
  logic [39:0] win_rd;
  logic signed [47:0] win_ext;
  logic [47:0] d_mag;
  logic [35:0] g_mag;
  logic [SqW-1:0] ww;
  logic [47:0] ef_mag;
  logic [48:0] ef_den;
  logic signed [51:0] b_num;
  logic [35:0] b_mag;
  logic signed [49:0] sh_sum;
  logic [WinW-1:0] w_new;
  logic [CountW-2:0] half_cnt;

  always_comb begin
    tsum = {2'b0, m_q.quantum_time} + {2'b0, m_q.classical_time}
         + {2'b0, m_q.link_overhead};
    usum = {2'b0, m_q.quantum_usage} + {2'b0, m_q.cpu_usage} + {2'b0, m_q.gpu_usage};
    s_num = ({7'b0, t_q} << 4) - {7'b0, t_q} + ({23'b0, m_q.fidelity_level} << 3)
          + {23'b0, m_q.fidelity_level} + 40'd393216 - ({21'b0, usum} << 1);
    // floor toward minus infinity for a negative score numerator
    s_mag = s_num[39] ? 36'(40'd0 - s_num + 40'd29) : s_num[35:0];
    bf2 = $signed({3'b0, m_q.cpu_usage}) + $signed({3'b0, m_q.gpu_usage})
        - $signed({2'b0, m_q.quantum_usage, 1'b0});
    bf2_mag = bf2[19] ? 20'(-bf2) : bf2;
    div_r = {rem_q[49:0], dn_q[63]};
    div_ge = div_r >= {1'b0, dd_q};
    win_rd = win_q[j_q[IdxW-1:0]];
    win_ext = {{8{win_rd[39]}}, win_rd};
    d_mag = d_q[47] ? 48'(-d_q) : d_q;
    g_mag = g_q[47] ? 36'(-g_q) : g_q[35:0];
    ww = SqW'(w_q) * SqW'(w_q);
    ef_mag = (ec_q >= eq_q) ? ec_q - eq_q : eq_q - ec_q;
    ef_den = {1'b0, eq_q} + {1'b0, ec_q};
    b_num = ($signed({{4{g_q[47]}}, g_q}) <<< 3)
          + ($signed({{34{ef_q[17]}}, ef_q}) <<< 2)
          + ($signed({{34{ef_q[17]}}, ef_q}) <<< 1)
          + ($signed({{32{bf2[19]}}, bf2}) <<< 1) + $signed({{32{bf2[19]}}, bf2});
    b_mag = b_num[51] ? 36'(-b_num) : b_num[35:0];
    sh_sum = $signed({34'b0, share_q}) + $signed({{2{step_q[47]}}, step_q});
    half_cnt = count_q[CountW-1:1];
    w_new = (half_cnt > (CountW-1)'(MaxWindow)) ? WinW'(MaxWindow) : WinW'(half_cnt);
    // low half of the dividend in S_KLO, high half in the S_KHI state that follows
    kmul_a = (st_q == S_KLO) ? kx_q[17:0] : kx_q[35:18];
    kprod = {43'b0, kmul_a} * {18'b0, km_q};
    kq = kacc_q[78:47];
  end

  assign in_i.ready  = (st_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ret_q       <= S_IDLE;
      mode_q      <= MODE_GRADIENT;
      en_q        <= 1'b1;
      share_q     <= ShareReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          RegStrategy: mode_q <= cfg_i.data.data[1:0];
          RegEnable:   en_q <= cfg_i.data.data[0];
          default: ;
        endcase
      end
      if (out_valid_q && out_o.ready && (st_q != S_OUT)) out_valid_q <= 1'b0;

      case (st_q)
        S_IDLE: begin
          if (in_i.valid) begin
            m_q     <= in_i.data;
            fault_q <= 1'b0;
            st_q    <= en_q ? S_TQ : S_OUT;
            ret_q   <= S_TQ;
            // flag a zero time sum in the next state, divider started there
            t_q     <= '0;
          end
        end
        S_TQ: begin
          if (ret_q == S_TQ) begin
            if (tsum == '0) begin
              t_q     <= 33'h1_0000_0000;
              fault_q <= 1'b1;
              st_q    <= S_SCORE;
            end else begin
              dn_q  <= {33'h1_0000_0000, 31'b0};
              dd_q  <= {16'b0, tsum};
              cnt_q <= 7'd33;
              rem_q <= '0;
              quo_q <= '0;
              ret_q <= S_SCORE;
              st_q  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q <= div_ge ? div_r - {1'b0, dd_q} : div_r;
          quo_q <= {quo_q[62:0], div_ge};
          dn_q  <= {dn_q[62:0], 1'b0};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) st_q <= ret_q;
        end
        S_KLO: begin
          kacc_q <= {18'b0, kprod};
          st_q   <= S_KHI;
        end
        S_KHI: begin
          kacc_q <= kacc_q + {kprod, 18'b0};
          st_q   <= ret_q;
        end
        S_SCORE: begin
          if (tsum != '0) t_q <= quo_q[32:0];
          st_q <= S_REC;
          ret_q <= S_IDLE;
        end
        S_REC: begin
          // t_q settled: divide the score numerator by 30
          if (ret_q == S_IDLE) begin
            neg_q <= s_num[39];
            kx_q  <= s_mag;
            km_q  <= Recip30;
            ret_q <= S_REC;
            st_q  <= S_KLO;
          end else begin
            if (count_q < CountW'(HistoryCapacity)) begin
              for (int i = WinDepth - 1; i > 0; i--) win_q[i] <= win_q[i-1];
              win_q[0] <= neg_q ? 40'(-{8'b0, kq}) : {8'b0, kq};
              count_q  <= count_q + 1'b1;
            end
            st_q <= S_WSET;
          end
        end
        S_WSET: begin
          w_q <= w_new;
          j_q <= '0;
          d_q <= '0;
          g_q <= '0;
          st_q <= (w_new == '0) ? S_MODE : S_ACC;
        end
        S_ACC: begin
          d_q <= (j_q < {1'b0, w_q}) ? d_q + win_ext : d_q - win_ext;
          j_q <= j_q + 1'b1;
          if (j_q == (IdxW+1)'({w_q, 1'b0} - 1'b1)) st_q <= S_GDIV;
        end
        S_GDIV: begin
          neg_q <= d_q[47];
          dn_q  <= {d_mag, 16'b0};
          dd_q  <= {{(50-SqW){1'b0}}, ww};
          cnt_q <= 7'd48;
          rem_q <= '0;
          quo_q <= '0;
          ret_q <= S_GQ;
          st_q  <= S_DIV;
        end
        S_GQ: begin
          g_q  <= neg_q ? -$signed(quo_q[47:0]) : $signed(quo_q[47:0]);
          st_q <= S_MODE;
        end
        S_MODE: begin
          rem_q <= '0;
          quo_q <= '0;
          case (mode_e'(mode_q))
            MODE_GRADIENT: begin
              neg_q <= g_q[47];
              kx_q  <= g_mag;
              km_q  <= Recip100;
              ret_q <= S_STEPQ;
              st_q  <= S_KLO;
            end
            MODE_BALANCE: begin
              neg_q <= bf2[19];
              kx_q  <= {16'b0, bf2_mag};
              km_q  <= Recip200;
              ret_q <= S_STEPQ;
              st_q  <= S_KLO;
            end
            default: st_q <= S_EQS;
          endcase
        end
        S_EQS: begin
          if (m_q.quantum_time == '0) begin
            eq_q    <= EffSat;
            fault_q <= 1'b1;
            st_q    <= S_ECS;
          end else begin
            dn_q  <= {m_q.q_energy, 32'b0};
            dd_q  <= {18'b0, m_q.quantum_time};
            cnt_q <= 7'd48;
            rem_q <= '0;
            quo_q <= '0;
            ret_q <= S_EQ;
            st_q  <= S_DIV;
          end
        end
        S_EQ: begin
          eq_q <= quo_q[47:0];
          st_q <= S_ECS;
        end
        S_ECS: begin
          if (m_q.classical_time == '0) begin
            ec_q    <= EffSat;
            fault_q <= 1'b1;
            st_q    <= S_EFS;
          end else begin
            dn_q  <= {m_q.c_energy, 32'b0};
            dd_q  <= {18'b0, m_q.classical_time};
            cnt_q <= 7'd48;
            rem_q <= '0;
            quo_q <= '0;
            ret_q <= S_EC;
            st_q  <= S_DIV;
          end
        end
        S_EC: begin
          ec_q <= quo_q[47:0];
          st_q <= S_EFS;
        end
        S_EFS: begin
          if (mode_e'(mode_q) == MODE_ENERGY) begin
            step_q <= (eq_q < ec_q) ? $signed(Step001) : -$signed(Step001);
            st_q   <= S_APPLY;
          end else if (ef_den == '0) begin
            ef_q    <= '0;
            fault_q <= 1'b1;
            st_q    <= S_BLEND;
          end else begin
            neg_q <= (ec_q < eq_q);
            dn_q  <= {ef_mag, 16'b0};
            dd_q  <= {1'b0, ef_den};
            cnt_q <= 7'd64;
            rem_q <= '0;
            quo_q <= '0;
            ret_q <= S_EFQ;
            st_q  <= S_DIV;
          end
        end
        S_EFQ: begin
          ef_q <= neg_q ? -$signed(quo_q[17:0]) : $signed(quo_q[17:0]);
          st_q <= S_BLEND;
        end
        S_BLEND: begin
          neg_q <= b_num[51];
          kx_q  <= b_mag;
          km_q  <= Recip2000;
          ret_q <= S_STEPQ;
          st_q  <= S_KLO;
        end
        S_STEPQ: begin
          step_q <= neg_q ? -$signed({16'b0, kq}) : $signed({16'b0, kq});
          st_q   <= S_APPLY;
        end
        S_APPLY: begin
          if (sh_sum < $signed({34'b0, ShareMin})) share_q <= ShareMin;
          else if (sh_sum > $signed({34'b0, ShareMax})) share_q <= ShareMax;
          else share_q <= sh_sum[15:0];
          st_q <= S_OUT;
        end
        S_OUT: begin
          // wait for the output slot to be free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q           <= 1'b1;
            out_q.quantum_share   <= share_q;
            out_q.classical_share <= 16'(17'h10000 - {1'b0, share_q});
            out_q.divide_fault    <= fault_q;
            st_q                  <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule
